// ===== rtl/core/adtsfs_pkg.sv =====
// ----------------------------------------------------------------------------
// adtsfs_pkg
// Shared types and constants of the ADTS frame synchronizer.
// ----------------------------------------------------------------------------
package adtsfs_pkg;

    localparam int FRAME_COUNT_BITS_DEF = 16;
    localparam int HDR_BYTES            = 6;
    localparam int QUEUE_DEPTH          = 4;

    localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
    localparam logic [3:0]  SYNC_NIBBLE   = 4'hF;
    localparam logic [12:0] MIN_FRAME_LEN = 13'd7;

    typedef enum logic [1:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEADER,
        PH_BODY
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [12:0] byte_index;
        logic [12:0] frame_length;
        logic [1:0]  profile;
        logic [3:0]  freq_index;
        logic [15:0] frame_number;
        logic        last_of_frame;
    } t_out_item;

    // one queue entry: either a whole header burst or one body byte
    typedef struct packed {
        logic                        burst;
        logic [HDR_BYTES-1:0][7:0]   bytes;
        logic [12:0]                 index;
        logic [12:0]                 length;
        logic [1:0]                  profile;
        logic [3:0]                  freq;
        logic [15:0]                 frame_num;
        logic                        last;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ===== rtl/core/adtsfs_stream_if.sv =====
// ----------------------------------------------------------------------------
// adtsfs_stream_if
// Valid/ready stream channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface adtsfs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/adtsfs_front.sv =====
// ----------------------------------------------------------------------------
// adtsfs_front
// Sync hunt, header capture and classification of stream bytes into commands.
// ----------------------------------------------------------------------------
module adtsfs_front #(
    parameter int FRAME_COUNT_BITS = adtsfs_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    adtsfs_stream_if.sink      i_in,
    input  adtsfs_pkg::t_q_stat i_q_stat,
    output logic               o_push,
    output adtsfs_pkg::t_cmd   o_cmd
);
    import adtsfs_pkg::*;

    t_phase                        r_phase, n_phase;
    logic [HDR_BYTES-1:0][7:0]     r_hdr, n_hdr;
    logic [2:0]                    r_hdr_cnt, n_hdr_cnt;
    logic [12:0]                   r_length, n_length;
    logic [12:0]                   r_pos, n_pos;
    logic [FRAME_COUNT_BITS-1:0]   r_frame_cnt, n_frame_cnt;

    logic        accept;
    logic [7:0]  b;
    logic [12:0] hdr_len;
    logic        is_last;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && !i_q_stat.full;
    assign b          = i_in.data.in_byte;
    assign hdr_len    = {r_hdr[3][1:0], r_hdr[4], b[7:5]};
    assign is_last    = ({1'b0, r_pos} + 14'd1) >= {1'b0, r_length};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT1;
            r_hdr_cnt   <= '0;
            r_length    <= '0;
            r_pos       <= '0;
            r_frame_cnt <= '0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_length    <= n_length;
            r_pos       <= n_pos;
            r_frame_cnt <= n_frame_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    always_comb begin
        n_phase     = r_phase;
        n_hdr       = r_hdr;
        n_hdr_cnt   = r_hdr_cnt;
        n_length    = r_length;
        n_pos       = r_pos;
        n_frame_cnt = r_frame_cnt;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.profile   = r_hdr[2][7:6];
        o_cmd.freq      = r_hdr[2][5:2];
        o_cmd.frame_num = 16'(r_frame_cnt);
        o_cmd.length    = r_length;

        if (accept) begin
            case (r_phase)
                PH_HUNT1: begin
                    if (b == SYNC_BYTE) begin
                        n_hdr[0] = b;
                        n_phase  = PH_HUNT2;
                    end
                end
                PH_HUNT2: begin
                    if (b[7:4] == SYNC_NIBBLE) begin
                        n_hdr[1]  = b;
                        n_hdr_cnt = 3'd2;
                        n_phase   = PH_HEADER;
                    end else begin
                        n_phase = PH_HUNT1;
                    end
                end
                PH_HEADER: begin
                    n_hdr[r_hdr_cnt] = b;
                    n_hdr_cnt        = r_hdr_cnt + 3'd1;
                    if (r_hdr_cnt == 3'(HDR_BYTES - 1)) begin
                        n_hdr_cnt = '0;
                        n_length  = hdr_len;
                        if (hdr_len < MIN_FRAME_LEN) begin
                            n_phase = PH_HUNT1;
                        end else begin
                            o_push       = 1'b1;
                            o_cmd.burst  = 1'b1;
                            o_cmd.bytes  = n_hdr;
                            o_cmd.length = hdr_len;
                            n_pos        = 13'(HDR_BYTES);
                            n_phase      = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    o_push         = 1'b1;
                    o_cmd.bytes[0] = b;
                    o_cmd.index    = r_pos;
                    o_cmd.last     = is_last;
                    n_pos          = r_pos + 13'd1;
                    if (is_last) begin
                        n_pos       = '0;
                        n_frame_cnt = r_frame_cnt + 1'b1;
                        n_phase     = PH_HUNT1;
                    end
                end
                default: begin
                    n_phase = PH_HUNT1;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/adtsfs_queue.sv =====
// ----------------------------------------------------------------------------
// adtsfs_queue
// Short register queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module adtsfs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  adtsfs_pkg::t_cmd    i_cmd,
    input  logic                i_pop,
    output adtsfs_pkg::t_cmd    o_head,
    output adtsfs_pkg::t_q_stat o_stat
);
    import adtsfs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/adtsfs_back.sv =====
// ----------------------------------------------------------------------------
// adtsfs_back
// Expands queued commands into result transactions through an output register.
// ----------------------------------------------------------------------------
module adtsfs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adtsfs_pkg::t_cmd    i_head,
    input  adtsfs_pkg::t_q_stat i_q_stat,
    output logic                o_pop,
    adtsfs_stream_if.source     o_out
);
    import adtsfs_pkg::*;

    logic       r_valid, n_valid;
    t_out_item  r_item, n_item;
    logic [2:0] r_sub, n_sub;
    logic       take;

    assign take        = !r_valid || o_out.ready;
    assign o_out.valid = r_valid;
    assign o_out.data  = r_item;

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        n_sub   = r_sub;
        o_pop   = 1'b0;
        if (take) begin
            n_valid = !i_q_stat.empty;
            if (!i_q_stat.empty) begin
                n_item.frame_length = i_head.length;
                n_item.profile      = i_head.profile;
                n_item.freq_index   = i_head.freq;
                n_item.frame_number = i_head.frame_num;
                if (i_head.burst) begin
                    n_item.data_byte     = i_head.bytes[r_sub];
                    n_item.byte_index    = 13'(r_sub);
                    n_item.last_of_frame = 1'b0;
                    if (r_sub == 3'(HDR_BYTES - 1)) begin
                        n_sub = '0;
                        o_pop = 1'b1;
                    end else begin
                        n_sub = r_sub + 3'd1;
                    end
                end else begin
                    n_item.data_byte     = i_head.bytes[0];
                    n_item.byte_index    = i_head.index;
                    n_item.last_of_frame = i_head.last;
                    o_pop                = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

// ===== rtl/core/adts_frame_synchronizer_top.sv =====
// ----------------------------------------------------------------------------
// adts_frame_synchronizer_top
// ADTS sync hunt and frame extraction from a raw AAC byte stream.
// ----------------------------------------------------------------------------
// The block takes one stream byte per input transaction and hunts for the
// ADTS sync word. Once six header bytes are in, frames with a length field of
// 7 or more are emitted byte by byte, header first, each tagged with length,
// profile, frequency index, position, frame number and a last flag; frames
// with a shorter length are dropped and hunting resumes. Input bytes are taken
// at one per cycle; each produces at most one entry in a four-entry command
// queue, and the output register drains one result per cycle while the output
// is ready, expanding a header entry into its six results. Input stalls only
// while the queue is full. With the queue and output register empty, the first
// result of an accepted byte passes the queue and then the output register.
// ----------------------------------------------------------------------------
module adts_frame_synchronizer_top #(
    parameter int FRAME_COUNT_BITS = adtsfs_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    adtsfs_stream_if.sink   i_in,
    adtsfs_stream_if.source o_out
);
    import adtsfs_pkg::*;

    logic    push;
    logic    pop;
    t_cmd    cmd;
    t_cmd    head;
    t_q_stat q_stat;

    adtsfs_front #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    adtsfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    adtsfs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
